### rtl/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

	localparam int SECONDS_WIDTH = 16;
	localparam int MS_WIDTH      = 32;
	localparam int STEP_WIDTH    = 12;
	localparam int PERIOD_WIDTH  = 16;
	localparam int ADJ_WIDTH     = 16;
	localparam int CNT_WIDTH     = $clog2(MS_WIDTH);
	localparam int PROD_WIDTH    = ADJ_WIDTH + STEP_WIDTH + 1;
	localparam int SUM_WIDTH     = (PROD_WIDTH > SECONDS_WIDTH ? PROD_WIDTH : SECONDS_WIDTH) + 1;

	localparam int IN_DATA_WIDTH  = 48;
	localparam int OUT_DATA_WIDTH = 24;
	localparam int APB_ADDR_WIDTH = 4;

	localparam logic [15:0] MAX_SECONDS_RST = 16'd5999;
	localparam logic [11:0] STEP_SECONDS_RST = 12'd60;
	localparam logic [15:0] PERIOD_MS_RST = 16'd1000;

	localparam logic [1:0] REG_MAX_SECONDS = 2'd0;
	localparam logic [1:0] REG_STEP_SECONDS = 2'd1;
	localparam logic [1:0] REG_PERIOD_MS = 2'd2;

	typedef enum logic [1:0] {
		CMD_CONFIRM = 2'd0,
		CMD_CANCEL  = 2'd1,
		CMD_ADJUST  = 2'd2,
		CMD_UPDATE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ADJ     = 3'd1,
		MODE_UPRUN   = 3'd2,
		MODE_UPPAUSE = 3'd3,
		MODE_DNRUN   = 3'd4,
		MODE_DNPAUSE = 3'd5,
		MODE_DONE    = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADJ,
		ST_DIV,
		ST_TICK,
		ST_PUB
	} state_t;

	typedef struct packed {
		logic [15:0]               max_seconds;
		logic [STEP_WIDTH-1:0]     step_seconds;
		logic [PERIOD_WIDTH-1:0]   period_ms;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic adj;
		logic div_step;
		logic tick;
		logic publish;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic upd_go;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/cst_regs.sv
`timescale 1ns / 1ps
module cst_regs
	import cst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_seconds  <= MAX_SECONDS_RST;
			cfg_q.step_seconds <= STEP_SECONDS_RST;
			cfg_q.period_ms    <= PERIOD_MS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_SECONDS:  cfg_q.max_seconds  <= pwdata[15:0];
				REG_STEP_SECONDS: cfg_q.step_seconds <= pwdata[STEP_WIDTH-1:0];
				REG_PERIOD_MS:    cfg_q.period_ms    <= pwdata[PERIOD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_SECONDS:  prdata = {16'd0, cfg_q.max_seconds};
			REG_STEP_SECONDS: prdata = {{(32-STEP_WIDTH){1'b0}}, cfg_q.step_seconds};
			REG_PERIOD_MS:    prdata = {{(32-PERIOD_WIDTH){1'b0}}, cfg_q.period_ms};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

### rtl/cst_ctrl.sv
`timescale 1ns / 1ps
module cst_ctrl
	import cst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				case (sts.cmd)
					CMD_ADJUST: state_d = ST_ADJ;
					CMD_UPDATE: state_d = sts.upd_go ? ST_DIV : ST_PUB;
					default:    state_d = ST_PUB;
				endcase
			end
			ST_ADJ: begin
				ctl.adj = 1'b1;
				state_d = ST_PUB;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				ctl.tick = 1'b1;
				state_d  = ST_PUB;
			end
			ST_PUB: begin
				// The next transaction is taken in the same cycle the result is published.
				if (sts.out_free) begin
					ctl.publish = 1'b1;
					s_tready    = 1'b1;
					if (s_tvalid) begin
						ctl.load = 1'b1;
						state_d  = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/cst_dp.sv
`timescale 1ns / 1ps
module cst_dp
	import cst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  ctl_t                      ctl,
	output sts_t                      sts,
	input  logic [1:0]                s_tuser,
	input  logic [IN_DATA_WIDTH-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_WIDTH-1:0] m_tdata
);

	cmd_t                          cmd_q;
	logic [MS_WIDTH-1:0]           now_q;
	logic signed [ADJ_WIDTH-1:0]   steps_q;
	mode_t                         mode_q;
	logic [SECONDS_WIDTH-1:0]      setting_q;
	logic [SECONDS_WIDTH-1:0]      count_q;
	logic [MS_WIDTH-1:0]           last_q;
	logic signed [PROD_WIDTH-1:0]  prod_q;
	logic [MS_WIDTH-1:0]           quo_q;
	logic [PERIOD_WIDTH-1:0]       rem_q;
	logic [CNT_WIDTH-1:0]          cnt_q;
	logic                          chg_q;
	logic                          out_valid_q;
	logic                          out_chg_q;
	logic [SECONDS_WIDTH-1:0]      out_shown_q;
	mode_t                         out_mode_q;
	logic                          out_run_q;

	logic                          running;
	logic                          setup_mode;
	logic [SECONDS_WIDTH-1:0]      lim;
	logic [MS_WIDTH-1:0]           elapsed;
	logic [PERIOD_WIDTH:0]         div_r;
	logic [PERIOD_WIDTH:0]         div_sub;
	logic                          div_ge;
	logic signed [SUM_WIDTH-1:0]   adj_sum;
	logic [SECONDS_WIDTH-1:0]      adj_next;
	logic [MS_WIDTH:0]             up_sum;
	logic [MS_WIDTH-1:0]           count_ext;
	logic [SECONDS_WIDTH-1:0]      tick_count;
	mode_t                         tick_mode;

	assign running    = (mode_q == MODE_UPRUN) || (mode_q == MODE_DNRUN);
	assign setup_mode = mode_q inside {MODE_IDLE, MODE_ADJ};
	assign lim        = SECONDS_WIDTH'(cfg.max_seconds);
	assign elapsed    = now_q - last_q;

	// One restoring division step per cycle: elapsed time over the tick period.
	assign div_r   = {rem_q, quo_q[MS_WIDTH-1]};
	assign div_sub = div_r - {1'b0, cfg.period_ms};
	assign div_ge  = div_r >= {1'b0, cfg.period_ms};

	always_comb begin
		adj_sum = $signed({{(SUM_WIDTH-SECONDS_WIDTH){1'b0}}, setting_q}) + SUM_WIDTH'(prod_q);
		if (adj_sum < 0) begin
			adj_next = '0;
		end else if (adj_sum > $signed({{(SUM_WIDTH-SECONDS_WIDTH){1'b0}}, lim})) begin
			adj_next = lim;
		end else begin
			adj_next = adj_sum[SECONDS_WIDTH-1:0];
		end
	end

	// Apply the whole number of elapsed periods held in the quotient.
	always_comb begin
		count_ext  = MS_WIDTH'(count_q);
		up_sum     = {1'b0, count_ext} + {1'b0, quo_q};
		tick_count = count_q;
		tick_mode  = mode_q;
		if (mode_q == MODE_UPRUN) begin
			if (count_q < lim) begin
				tick_count = (up_sum > (MS_WIDTH + 1)'(lim)) ? lim : up_sum[SECONDS_WIDTH-1:0];
			end
		end else if (count_ext > quo_q) begin
			tick_count = count_q - quo_q[SECONDS_WIDTH-1:0];
		end else begin
			tick_count = '0;
			tick_mode  = MODE_DONE;
		end
	end

	assign sts.cmd      = cmd_q;
	assign sts.upd_go   = running && (cfg.period_ms != '0);
	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(s_tuser);
			now_q   <= s_tdata[MS_WIDTH-1:0];
			steps_q <= $signed(s_tdata[32 +: ADJ_WIDTH]);
		end
		if (ctl.exec && cmd_q == CMD_ADJUST) begin
			prod_q <= PROD_WIDTH'(steps_q) * PROD_WIDTH'($signed({1'b0, cfg.step_seconds}));
		end
		if (ctl.exec && cmd_q == CMD_UPDATE) begin
			quo_q <= elapsed;
			rem_q <= '0;
			cnt_q <= CNT_WIDTH'(MS_WIDTH - 1);
		end else if (ctl.div_step) begin
			quo_q <= {quo_q[MS_WIDTH-2:0], div_ge};
			rem_q <= div_ge ? div_sub[PERIOD_WIDTH-1:0] : div_r[PERIOD_WIDTH-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
		if (ctl.exec) begin
			chg_q <= 1'b0;
		end else if (ctl.adj) begin
			chg_q <= (steps_q != '0) && setup_mode &&
				((adj_next != setting_q) || (mode_q != MODE_ADJ));
		end else if (ctl.tick) begin
			chg_q <= (quo_q != '0) && ((tick_count != count_q) || (tick_mode != mode_q));
		end
		if (ctl.publish) begin
			out_chg_q   <= chg_q;
			out_shown_q <= setup_mode ? setting_q : count_q;
			out_mode_q  <= mode_q;
			out_run_q   <= running;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			setting_q   <= '0;
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				case (cmd_q)
					CMD_CONFIRM: begin
						last_q <= now_q;
						case (mode_q)
							MODE_IDLE, MODE_ADJ: begin
								if (setting_q != '0) begin
									count_q <= setting_q;
									mode_q  <= MODE_DNRUN;
								end else begin
									count_q <= '0;
									mode_q  <= MODE_UPRUN;
								end
							end
							MODE_UPRUN:   mode_q <= MODE_UPPAUSE;
							MODE_UPPAUSE: mode_q <= MODE_UPRUN;
							MODE_DNRUN:   mode_q <= MODE_DNPAUSE;
							MODE_DNPAUSE: mode_q <= MODE_DNRUN;
							default: begin
								mode_q    <= MODE_IDLE;
								setting_q <= '0;
								count_q   <= '0;
								last_q    <= '0;
							end
						endcase
					end
					CMD_CANCEL: begin
						mode_q    <= MODE_IDLE;
						setting_q <= '0;
						count_q   <= '0;
						last_q    <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.adj && steps_q != '0 && setup_mode) begin
				setting_q <= adj_next;
				mode_q    <= MODE_ADJ;
			end
			if (ctl.tick && quo_q != '0) begin
				// Advancing by whole periods leaves the mark at now minus the remainder.
				last_q  <= now_q - MS_WIDTH'(rem_q);
				count_q <= tick_count;
				mode_q  <= tick_mode;
			end
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_run_q, out_mode_q, out_shown_q, out_chg_q};

endmodule

### rtl/countdown_stopwatch_timer.sv
`timescale 1ns / 1ps
// Countdown and stopwatch timer. Each transaction on the slave stream is one command
// (confirm, cancel, adjust, time update) and produces exactly one result transaction
// on the master stream carrying the changed flag, the displayed seconds, the mode and
// the running flag. Limits, adjust step and tick period sit in the APB registers at
// byte addresses 0, 4 and 8; write them only while no command is in flight.
// Confirm and cancel pass through the execute and publish states, adjust adds an adjust
// state, and an update that finds the timer running steps the bit-serial divider that
// turns the elapsed milliseconds into whole tick periods, one quotient bit per cycle,
// then a tick state before publishing. The result goes into the output register in the
// publish state, and the block can take the next command in that same cycle.
// The result sits in an output register, so a new command is accepted while it
// waits; if the receiver still stalls when the next result is ready, that command
// holds and s_tready stays low until the output register empties.
// Reset clears the timer to idle with a zero setting and count and restores the
// register defaults (5999 s limit, 60 s step, 1000 ms period).
module countdown_stopwatch_timer
	import cst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // now_ms[31:0], adjust_steps[47:32]
	input  logic [1:0]                s_tuser,   // command[1:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_WIDTH-1:0] m_tdata,   // changed[0], shown_seconds[16:1],
	                                             // mode[19:17], running[20]
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	cst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	cst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ctl      (ctl),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### verif/cst_checker.sv
`timescale 1ns / 1ps
module cst_checker
	import cst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // now_ms[31:0], adjust_steps[47:32]
	input  logic [1:0]                s_tuser,   // command[1:0]
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_DATA_WIDTH-1:0] m_tdata,   // changed[0], shown_seconds[16:1],
	                                             // mode[19:17], running[20]
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]               pwdata,
	input  logic                      pready,
	output int                        pending,
	output int                        err_count
);

	typedef struct packed {
		logic        changed;
		logic [15:0] shown;
		mode_t       mode;
		logic        running;
	} display_t;

	logic [15:0] cfg_max;
	logic [11:0] cfg_step;
	logic [15:0] cfg_period;

	mode_t       cur_mode;
	logic [15:0] cur_setting;
	logic [15:0] cur_count;
	logic [31:0] cur_last;

	display_t    expected_displays[$];
	display_t    want;

	function automatic void clear_timer();
		cur_mode    = MODE_IDLE;
		cur_setting = '0;
		cur_count   = '0;
		cur_last    = '0;
	endfunction

	function automatic display_t next_display(cmd_t cmd, logic [31:0] now, logic [15:0] steps_raw);
		display_t          r;
		longint            target;
		longint unsigned   ticks;
		logic [31:0]       elapsed;
		logic [15:0]       old_count;
		mode_t             old_mode;
		r.changed = 1'b0;
		old_count = cur_count;
		old_mode  = cur_mode;
		case (cmd)
			CMD_CONFIRM: begin
				case (cur_mode)
					MODE_IDLE, MODE_ADJ: begin
						cur_count = cur_setting;
						cur_mode  = (cur_setting != 0) ? MODE_DNRUN : MODE_UPRUN;
						cur_last  = now;
					end
					MODE_UPRUN: begin
						cur_mode = MODE_UPPAUSE;
						cur_last = now;
					end
					MODE_UPPAUSE: begin
						cur_mode = MODE_UPRUN;
						cur_last = now;
					end
					MODE_DNRUN: begin
						cur_mode = MODE_DNPAUSE;
						cur_last = now;
					end
					MODE_DNPAUSE: begin
						cur_mode = MODE_DNRUN;
						cur_last = now;
					end
					default: clear_timer();
				endcase
			end
			CMD_CANCEL: clear_timer();
			CMD_ADJUST: begin
				if (steps_raw != 0 && (cur_mode == MODE_IDLE || cur_mode == MODE_ADJ)) begin
					target = longint'(cur_setting) +
					         longint'($signed(steps_raw)) * longint'(cfg_step);
					if (target < 0)
						target = 0;
					if (target > longint'(cfg_max))
						target = longint'(cfg_max);
					r.changed   = (target[15:0] != cur_setting) || (cur_mode != MODE_ADJ);
					cur_setting = target[15:0];
					cur_mode    = MODE_ADJ;
				end
			end
			default: begin
				if ((cur_mode == MODE_UPRUN || cur_mode == MODE_DNRUN) && cfg_period != 0) begin
					elapsed = now - cur_last;
					ticks   = longint'(elapsed) / longint'(cfg_period);
					if (ticks != 0) begin
						// The tick mark moves by whole periods only, so leftover time carries over.
						cur_last = cur_last + 32'(ticks * longint'(cfg_period));
						if (cur_mode == MODE_UPRUN) begin
							if (cur_count < cfg_max) begin
								if (longint'(cur_count) + ticks > longint'(cfg_max))
									cur_count = cfg_max;
								else
									cur_count = cur_count + 16'(ticks);
							end
						end else if (longint'(cur_count) > ticks) begin
							cur_count = cur_count - 16'(ticks);
						end else begin
							cur_count = '0;
							cur_mode  = MODE_DONE;
						end
						r.changed = (cur_count != old_count) || (cur_mode != old_mode);
					end
				end
			end
		endcase
		r.shown   = (cur_mode == MODE_IDLE || cur_mode == MODE_ADJ) ? cur_setting : cur_count;
		r.mode    = cur_mode;
		r.running = (cur_mode == MODE_UPRUN || cur_mode == MODE_DNRUN);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint exp_val);
		$display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_max    = MAX_SECONDS_RST;
			cfg_step   = STEP_SECONDS_RST;
			cfg_period = PERIOD_MS_RST;
			clear_timer();
			expected_displays.delete();
			pending   = 0;
			err_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MAX_SECONDS:  cfg_max    = pwdata[15:0];
					REG_STEP_SECONDS: cfg_step   = pwdata[11:0];
					REG_PERIOD_MS:    cfg_period = pwdata[15:0];
					default: ;
				endcase
			end
			// A result can never belong to a command accepted at the same edge.
			if (m_tvalid && m_tready) begin
				if (expected_displays.size() == 0) begin
					report_mismatch("unexpected result, tdata", longint'(m_tdata), 0);
				end else begin
					want = expected_displays.pop_front();
					if (m_tdata[0] != want.changed)
						report_mismatch("changed", m_tdata[0], want.changed);
					if (m_tdata[16:1] != want.shown)
						report_mismatch("shown_seconds", m_tdata[16:1], want.shown);
					if (m_tdata[19:17] != want.mode)
						report_mismatch("mode", m_tdata[19:17], want.mode);
					if (m_tdata[20] != want.running)
						report_mismatch("running", m_tdata[20], want.running);
				end
			end
			if (s_tvalid && s_tready)
				expected_displays.push_back(next_display(cmd_t'(s_tuser), s_tdata[31:0],
				                                         s_tdata[47:32]));
			pending = expected_displays.size();
		end
	end

endmodule

### verif/tb_countdown_stopwatch_timer.sv
`timescale 1ns / 1ps
module tb_countdown_stopwatch_timer
	import cst_pkg::*;
;

	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 90;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_DATA_WIDTH-1:0]  s_tdata;   // now_ms[31:0], adjust_steps[47:32]
	logic [1:0]                s_tuser;   // command[1:0]
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;   // changed[0], shown_seconds[16:1],
	                                      // mode[19:17], running[20]
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	int          pending;
	int          err_count;
	logic        sender_nogap;
	logic        receiver_nogap;
	logic        hold_req;
	logic [31:0] now_ms;
	logic [15:0] period_ms;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	countdown_stopwatch_timer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cst_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.pending   (pending),
		.err_count (err_count)
	);

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_cmd(input cmd_t cmd, input logic [31:0] now, input logic [15:0] steps);
		int gap;
		gap = sender_nogap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {steps, now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Leaves the bus selected so writes can follow back to back; the caller releases it.
	task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_timer_config(input logic [15:0] max_s, input logic [11:0] step_s,
	                                input logic [15:0] period);
		wait_drained();
		apb_write(REG_MAX_SECONDS, {16'd0, max_s});
		apb_write(REG_STEP_SECONDS, {20'd0, step_s});
		apb_write(REG_PERIOD_MS, {16'd0, period});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		period_ms = period;
	endtask

	task automatic random_config();
		int          profile;
		logic [15:0] max_s;
		logic [11:0] step_s;
		logic [15:0] period;
		profile = $urandom_range(0, 5);
		if (profile <= 2) begin
			max_s  = 16'($urandom_range(1, 50));
			step_s = 12'($urandom_range(1, 8));
			period = 16'($urandom_range(1, 40));
		end else if (profile == 3) begin
			max_s  = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			step_s = $urandom_range(0, 1) ? 12'hFFF : 12'd1;
			period = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
		end else if (profile == 4) begin
			max_s  = 16'($urandom);
			step_s = 12'($urandom);
			period = 16'($urandom);
		end else begin
			max_s  = MAX_SECONDS_RST;
			step_s = STEP_SECONDS_RST;
			period = ($urandom_range(0, 3) == 0) ? 16'd0 : PERIOD_MS_RST;
		end
		set_timer_config(max_s, step_s, period);
	endtask

	// Mostly a steady timestamp with updates a few periods apart, so runs reach their ends.
	task automatic random_command();
		int          pick;
		int          jump;
		logic [31:0] span;
		logic [15:0] steps;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			send_cmd(CMD_CONFIRM, now_ms, 16'($urandom));
		end else if (pick < 16) begin
			send_cmd(CMD_CANCEL, $urandom, 16'($urandom));
		end else if (pick < 36) begin
			if ($urandom_range(0, 4) == 0)
				steps = 16'($urandom);
			else
				steps = 16'($urandom_range(0, 6)) - 16'd3;
			send_cmd(CMD_ADJUST, $urandom, steps);
		end else if (pick < 94) begin
			jump = $urandom_range(0, 9);
			span = (period_ms == 0) ? 32'd50 : 32'(period_ms);
			if (jump < 8)
				now_ms = now_ms + $urandom_range(0, 3 * span);
			else if (jump == 8)
				now_ms = now_ms + $urandom_range(0, 100 * span);
			else
				now_ms = now_ms + $urandom;
			send_cmd(CMD_UPDATE, now_ms, 16'($urandom));
		end else begin
			now_ms = $urandom;
			send_cmd(pick[0] ? CMD_UPDATE : CMD_CONFIRM, now_ms, 16'($urandom));
		end
	endtask

	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				gap      = HOLD_CYCLES;
			end else begin
				gap = receiver_nogap ? 0 : $urandom_range(0, 9);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("countdown_stopwatch_timer test failed");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int item;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = CMD_CONFIRM;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		sender_nogap   = 1'b0;
		receiver_nogap = 1'b0;
		hold_req       = 1'b0;
		now_ms         = '0;
		period_ms      = PERIOD_MS_RST;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: ignored commands, adjust saturation both ways, count-up.
		send_cmd(CMD_UPDATE, 32'd500, 16'd0);
		send_cmd(CMD_ADJUST, 32'd0, 16'd0);
		send_cmd(CMD_ADJUST, 32'd0, 16'd1);
		send_cmd(CMD_ADJUST, 32'd0, 16'h7FFF);
		send_cmd(CMD_ADJUST, 32'd0, 16'h8000);
		send_cmd(CMD_CONFIRM, 32'd1000, 16'd0);
		send_cmd(CMD_ADJUST, 32'd0, 16'd1);
		send_cmd(CMD_UPDATE, 32'd1999, 16'd0);
		send_cmd(CMD_UPDATE, 32'd2000, 16'd0);
		send_cmd(CMD_UPDATE, 32'd10_002_000, 16'd0);
		send_cmd(CMD_CONFIRM, 32'd10_002_500, 16'd0);
		send_cmd(CMD_UPDATE, 32'd10_009_000, 16'd0);
		send_cmd(CMD_CONFIRM, 32'd10_003_000, 16'd0);
		send_cmd(CMD_CANCEL, 32'hFFFF_FFFF, 16'hFFFF);
		// Countdown across the timestamp wrap, then a huge gap that finishes it.
		send_cmd(CMD_ADJUST, 32'd0, 16'd2);
		send_cmd(CMD_CONFIRM, 32'hFFFF_FF00, 16'd0);
		send_cmd(CMD_UPDATE, 32'h0000_0300, 16'd0);
		send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 16'd0);
		send_cmd(CMD_ADJUST, 32'd0, 16'd1);
		send_cmd(CMD_UPDATE, 32'h0000_0000, 16'd0);
		send_cmd(CMD_CONFIRM, 32'd0, 16'd0);
		// Widest limit and step with a zero period: updates never tick.
		set_timer_config(16'hFFFF, 12'hFFF, 16'd0);
		send_cmd(CMD_ADJUST, 32'd0, 16'h7FFF);
		send_cmd(CMD_CONFIRM, 32'd0, 16'd0);
		send_cmd(CMD_UPDATE, 32'd12345, 16'd0);
		send_cmd(CMD_CANCEL, 32'd0, 16'd0);
		// A count-up left above a lowered limit stays where it is.
		set_timer_config(16'hFFFF, 12'hFFF, 16'd1);
		send_cmd(CMD_CONFIRM, 32'd0, 16'd0);
		send_cmd(CMD_UPDATE, 32'd100, 16'd0);
		set_timer_config(16'd1, 12'd1, 16'd1);
		send_cmd(CMD_UPDATE, 32'd200, 16'd0);
		now_ms = 32'd200;

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config();
			sender_nogap   = (phase % 4 == 1);
			receiver_nogap = (phase % 3 == 2);
			if (phase == 3) begin
				// Stall the results for a long stretch while commands keep coming.
				sender_nogap = 1'b1;
				hold_req     = 1'b1;
			end
			for (item = 0; item < PHASE_ITEMS; item++) begin
				if (phase == 6 && item == PHASE_ITEMS / 2)
					wait_drained();
				random_command();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0 && pending == 0)
			$display("countdown_stopwatch_timer test passed");
		else
			$display("countdown_stopwatch_timer test failed");
		$finish;
	end

endmodule
